// ----- sv/rlpd_pkg.sv -----
`default_nettype none

package rlpd_pkg;

   // Default sizing of the decoder.
   localparam int RLPD_MAX_DEPTH = 16;
   localparam int RLPD_LEN_BITS  = 32;

   // Header byte boundaries of the encoding.
   localparam logic [7:0] BYTE_SINGLE_MAX     = 8'h7f;
   localparam logic [7:0] BYTE_STR_BASE       = 8'h80;
   localparam logic [7:0] BYTE_STR_SHORT_MAX  = 8'hb7;
   localparam logic [7:0] BYTE_STR_LONG_MAX   = 8'hbf;
   localparam logic [7:0] BYTE_LIST_BASE      = 8'hc0;
   localparam logic [7:0] BYTE_LIST_SHORT_MAX = 8'hf7;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LEN,
      PH_STR,
      PH_REM,
      PH_DRAIN
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD,
      KIND_EMPTY,
      KIND_REMAINDER,
      KIND_ERROR
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE,
      ERR_DEPTH,
      ERR_OVERRUN,
      ERR_NONCANON,
      ERR_EMPTY_LIST,
      ERR_TOO_WIDE
   } err_type;

   // Update request from the byte decoder to the list stack.
   typedef struct packed {
      logic top_wr;
      logic push;
      logic settle;
   } stack_op_type;

endpackage

`default_nettype wire

// ----- sv/rlpd_req_if.sv -----
`default_nettype none

interface rlpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       msg_last;

   modport source (output valid, output in_byte, output msg_last, input ready);
   modport sink (input valid, input in_byte, input msg_last, output ready);
endinterface

`default_nettype wire

// ----- sv/rlpd_rsp_if.sv -----
`default_nettype none

interface rlpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       item_first;
   logic       item_last;
   logic [4:0] nest_level;
   logic [2:0] error_code;
   logic       msg_end;

   modport source (
      output valid, output kind, output out_byte, output item_first,
      output item_last, output nest_level, output error_code, output msg_end,
      input ready
   );
   modport sink (
      input valid, input kind, input out_byte, input item_first,
      input item_last, input nest_level, input error_code, input msg_end,
      output ready
   );
endinterface

`default_nettype wire

// ----- sv/rlpd_list_stack.sv -----
`default_nettype none

module rlpd_list_stack
   import rlpd_pkg::*;
#(
   parameter int MAX_DEPTH = RLPD_MAX_DEPTH,
   parameter int LEN_BITS  = RLPD_LEN_BITS,
   localparam int DEPTH = MAX_DEPTH + 1,
   localparam int LVL_W = $clog2(MAX_DEPTH + 2),
   localparam int IDX_W = $clog2(MAX_DEPTH + 1)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                apply,
   input  wire logic                clear,
   input  wire stack_op_type        op,
   input  wire logic [LEN_BITS-1:0] top_val,
   input  wire logic [LEN_BITS-1:0] push_val,
   output logic      [LVL_W-1:0]    level,
   output logic      [LEN_BITS-1:0] top,
   output logic                     settled_empty
);

   logic [LEN_BITS-1:0] entry_ff [DEPTH];
   logic [LEN_BITS-1:0] entry_in [DEPTH];
   logic [DEPTH-1:0]    zero_ff;
   logic [DEPTH-1:0]    zero_in;
   logic [LVL_W-1:0]    level_ff;
   logic [LVL_W-1:0]    level_in;
   logic [LVL_W-1:0]    level_m1;
   logic [IDX_W-1:0]    top_idx;
   logic [LVL_W-1:0]    level_post;
   logic [LVL_W-1:0]    settled_level;
   logic [DEPTH-1:0]    live;
   logic                top_wr_ok;

   // The open list on top holds the remaining byte count of the innermost list.
   assign level_m1  = level_ff - LVL_W'(1);
   assign top_idx   = level_m1[IDX_W-1:0];
   assign top       = (level_ff == '0) ? '0 : entry_ff[top_idx];
   assign level     = level_ff;
   assign top_wr_ok = op.top_wr && (level_ff != '0);

   // Entry contents and zero flags after this item's writes.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
         zero_in[i]  = zero_ff[i];
         if (op.push && (LVL_W'(i) == level_ff)) begin
            entry_in[i] = push_val;
            zero_in[i]  = (push_val == '0);
         end else if (top_wr_ok && (LVL_W'(i) == level_m1)) begin
            entry_in[i] = top_val;
            zero_in[i]  = (top_val == '0);
         end
      end
   end

   // Closing finished lists: the new level sits just above the highest open
   // list that still has unclaimed bytes.
   always_comb begin
      level_post    = op.push ? level_ff + LVL_W'(1) : level_ff;
      settled_level = '0;
      for (int i = 0; i < DEPTH; i++) begin
         live[i] = (LVL_W'(i) < level_post) && !zero_in[i];
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (live[i]) begin
            settled_level = LVL_W'(i + 1);
         end
      end
      settled_empty = (settled_level == '0);
   end

   always_comb begin
      level_in = level_ff;
      if (clear) begin
         level_in = '0;
      end else if (apply) begin
         level_in = op.settle ? settled_level : level_post;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
      end else begin
         level_ff <= level_in;
      end
   end

   // Entries are only read below the current level, which were all written.
   always_ff @(posedge clock) begin
      if (apply) begin
         entry_ff <= entry_in;
         zero_ff  <= zero_in;
      end
   end

endmodule

`default_nettype wire

// ----- sv/rlp_stream_decoder.sv -----
`default_nettype none

// Streaming RLP decoder. Message bytes enter on req_ch, one item per byte, with
// msg_last on the final byte; the first top-level item is decoded with nested
// lists flattened, so rsp_ch carries each string payload byte (with first and
// last marks and its nesting level), an empty-item mark for an empty string,
// each byte after the top item as a remainder byte, or a single error item,
// after which the block stays silent until msg_last. List headers and length
// bytes give no result. The block takes one byte per clock cycle with no gap
// between messages while rsp_ch.ready does not hold back results; a byte's
// result passes from the input register through the one-pass decode to the
// result register and on to rsp_ch, and the input register plus the result
// register let a new byte in while a result waits for rsp_ch.ready. Up to
// MAX_DEPTH + 1 nested lists are tracked; lengths are limited to LEN_BITS
// bits. Every msg_last byte returns the decoder to its idle state.
module rlp_stream_decoder
   import rlpd_pkg::*;
#(
   parameter int MAX_DEPTH = RLPD_MAX_DEPTH,
   parameter int LEN_BITS  = RLPD_LEN_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   rlpd_req_if.sink  req_ch,
   rlpd_rsp_if.source rsp_ch
);

   localparam int LVL_W = $clog2(MAX_DEPTH + 2);

   // Input register.
   logic       hold_valid_ff;
   logic [7:0] hold_byte_ff;
   logic       hold_last_ff;

   // Decode state.
   phase_type           phase_ff;
   phase_type           phase_in;
   logic [LEN_BITS-1:0] accum_ff;
   logic [LEN_BITS-1:0] accum_in;
   logic [3:0]          left_ff;
   logic [3:0]          left_in;
   logic                pend_list_ff;
   logic                pend_list_in;
   logic [LEN_BITS-1:0] srem_ff;
   logic [LEN_BITS-1:0] srem_in;
   logic                sfirst_ff;
   logic                sfirst_in;
   logic                short_one_ff;
   logic                short_one_in;

   // Result register.
   logic      rsp_valid_ff;
   kind_type  rsp_kind_ff;
   logic [7:0] rsp_byte_ff;
   logic      rsp_first_ff;
   logic      rsp_last_ff;
   logic [4:0] rsp_nest_ff;
   err_type   rsp_err_ff;
   logic      rsp_end_ff;

   // Handshake.
   logic out_free;
   logic adv;
   logic req_ready;

   // Stack connection.
   stack_op_type        op;
   logic                stack_apply;
   logic                stack_clear;
   logic [LEN_BITS-1:0] top_val;
   logic [LEN_BITS-1:0] push_val;
   logic [LVL_W-1:0]    level;
   logic [LEN_BITS-1:0] top;
   logic                settled_empty;

   // Decode datapath.
   logic [7:0]          b;
   logic                lvl_open;
   logic [7:0]          n8;
   logic [7:0]          hdr_need;
   logic [LEN_BITS:0]   hdr_diff;
   logic [LEN_BITS-1:0] top_m1;
   logic [LEN_BITS-1:0] acc_new;
   logic [3:0]          left_new;
   logic [LEN_BITS:0]   fit_sum;
   logic                too_wide;

   // Result of the current byte.
   logic      emit;
   logic      in_item;
   logic      done;
   logic      has_result;
   kind_type  res_kind;
   logic [7:0] res_byte;
   logic      res_first;
   logic      res_last;
   logic [4:0] res_nest;
   err_type   res_err;

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign adv       = hold_valid_ff && out_free;
   assign req_ready = !hold_valid_ff || adv;
   assign req_ch.ready = req_ready;

   // Input register: takes a byte when it is empty or the held one moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_ready) begin
         hold_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_ch.valid) begin
         hold_byte_ff <= req_ch.in_byte;
         hold_last_ff <= req_ch.msg_last;
      end
   end

   assign b        = hold_byte_ff;
   assign lvl_open = (level != '0);

   // Header length field and the bytes the header claims from its list:
   // the header byte itself plus a short payload, or the length-of-length.
   always_comb begin
      if (b <= BYTE_SINGLE_MAX) begin
         n8 = '0;
      end else if (b <= BYTE_STR_SHORT_MAX) begin
         n8 = b - BYTE_STR_BASE;
      end else if (b <= BYTE_STR_LONG_MAX) begin
         n8 = b - BYTE_STR_SHORT_MAX;
      end else if (b <= BYTE_LIST_SHORT_MAX) begin
         n8 = b - BYTE_LIST_BASE;
      end else begin
         n8 = b - BYTE_LIST_SHORT_MAX;
      end
      hdr_need = n8 + 8'd1;
   end

   assign hdr_diff = {1'b0, top} - (LEN_BITS + 1)'(hdr_need);
   assign top_m1   = top - LEN_BITS'(1);

   // Length bytes: accumulate big-endian, then check the payload fits the
   // list after this length byte is claimed.
   assign too_wide = (accum_ff[LEN_BITS-1 -: 8] != 8'd0);
   assign acc_new  = (accum_ff << 8) | LEN_BITS'(b);
   assign left_new = left_ff - 4'd1;
   assign fit_sum  = {1'b0, top} + {1'b0, ~acc_new};

   // One-pass decode of the held byte.
   always_comb begin
      emit         = 1'b0;
      in_item      = 1'b0;
      res_kind     = KIND_PAYLOAD;
      res_byte     = '0;
      res_first    = 1'b0;
      res_last     = 1'b0;
      res_nest     = 5'(level);
      res_err      = ERR_NONE;
      phase_in     = phase_ff;
      accum_in     = accum_ff;
      left_in      = left_ff;
      pend_list_in = pend_list_ff;
      srem_in      = srem_ff;
      sfirst_in    = sfirst_ff;
      short_one_in = short_one_ff;
      op           = '0;
      top_val      = top_m1;
      push_val     = '0;

      case (phase_ff)
         PH_REM: begin
            emit     = 1'b1;
            res_kind = KIND_REMAINDER;
            res_byte = b;
            res_nest = '0;
         end
         PH_DRAIN: begin
            emit = 1'b0;
         end
         PH_LEN: begin
            in_item   = 1'b1;
            op.top_wr = 1'b1;
            if (too_wide) begin
               res_err = ERR_TOO_WIDE;
            end else begin
               accum_in = acc_new;
               left_in  = left_new;
               if (left_new == 4'd0) begin
                  if (lvl_open && !fit_sum[LEN_BITS]) begin
                     res_err = ERR_OVERRUN;
                  end else if (pend_list_ff && (acc_new == '0)) begin
                     res_err = ERR_EMPTY_LIST;
                  end else begin
                     top_val = fit_sum[LEN_BITS-1:0];
                     if (pend_list_ff) begin
                        op.push   = 1'b1;
                        push_val  = acc_new;
                        op.settle = 1'b1;
                        phase_in  = PH_IDLE;
                     end else if (acc_new == '0) begin
                        emit      = 1'b1;
                        res_kind  = KIND_EMPTY;
                        op.settle = 1'b1;
                        phase_in  = PH_IDLE;
                     end else begin
                        srem_in   = acc_new;
                        sfirst_in = 1'b1;
                        phase_in  = PH_STR;
                     end
                  end
               end
            end
         end
         PH_STR: begin
            in_item = 1'b1;
            if (sfirst_ff && short_one_ff && (b < BYTE_STR_BASE)) begin
               res_err = ERR_NONCANON;
            end else begin
               emit      = 1'b1;
               res_byte  = b;
               res_first = sfirst_ff;
               res_last  = (srem_ff == LEN_BITS'(1));
               sfirst_in = 1'b0;
               srem_in   = srem_ff - LEN_BITS'(1);
               if (srem_ff == LEN_BITS'(1)) begin
                  op.settle = 1'b1;
                  phase_in  = PH_IDLE;
               end
            end
         end
         default: begin
            // Header byte.
            in_item = 1'b1;
            if (level > LVL_W'(MAX_DEPTH)) begin
               res_err = ERR_DEPTH;
            end else if (lvl_open && hdr_diff[LEN_BITS]) begin
               res_err = ERR_OVERRUN;
            end else begin
               op.top_wr    = 1'b1;
               top_val      = hdr_diff[LEN_BITS-1:0];
               short_one_in = 1'b0;
               if (b <= BYTE_SINGLE_MAX) begin
                  emit      = 1'b1;
                  res_byte  = b;
                  res_first = 1'b1;
                  res_last  = 1'b1;
                  op.settle = 1'b1;
               end else if (b <= BYTE_STR_SHORT_MAX) begin
                  short_one_in = (n8 == 8'd1);
                  if (n8 == 8'd0) begin
                     emit      = 1'b1;
                     res_kind  = KIND_EMPTY;
                     op.settle = 1'b1;
                  end else begin
                     srem_in   = LEN_BITS'(n8);
                     sfirst_in = 1'b1;
                     phase_in  = PH_STR;
                  end
               end else if ((b <= BYTE_STR_LONG_MAX) || (b > BYTE_LIST_SHORT_MAX)) begin
                  // Long form: only the header byte is claimed here.
                  top_val      = top_m1;
                  pend_list_in = (b > BYTE_LIST_SHORT_MAX);
                  left_in      = n8[3:0];
                  accum_in     = '0;
                  phase_in     = PH_LEN;
               end else begin
                  op.push   = 1'b1;
                  push_val  = LEN_BITS'(n8);
                  op.settle = 1'b1;
               end
            end
         end
      endcase

      // Errors send the rest of the message to the drain.
      if (res_err != ERR_NONE) begin
         phase_in = PH_DRAIN;
         op       = '0;
      end

      // The top item is complete once every open list is closed.
      done = op.settle && settled_empty;
      if (done) begin
         phase_in = PH_REM;
      end

      // A message that ends inside the top item overruns.
      if (hold_last_ff && in_item && (res_err == ERR_NONE) && !done) begin
         res_err = ERR_OVERRUN;
      end

      if (res_err != ERR_NONE) begin
         res_kind  = KIND_ERROR;
         res_byte  = '0;
         res_first = 1'b0;
         res_last  = 1'b0;
         res_nest  = '0;
      end
      has_result = emit || (res_err != ERR_NONE);
   end

   assign stack_apply = adv && (res_err == ERR_NONE) && !hold_last_ff;
   assign stack_clear = adv && hold_last_ff;

   rlpd_list_stack #(
      .MAX_DEPTH (MAX_DEPTH),
      .LEN_BITS  (LEN_BITS)
   ) u_stack (
      .clock         (clock),
      .reset         (reset),
      .apply         (stack_apply),
      .clear         (stack_clear),
      .op            (op),
      .top_val       (top_val),
      .push_val      (push_val),
      .level         (level),
      .top           (top),
      .settled_empty (settled_empty)
   );

   // Phase register: the last byte of a message always returns to idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (adv) begin
         phase_ff <= hold_last_ff ? PH_IDLE : phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         accum_ff     <= accum_in;
         left_ff      <= left_in;
         pend_list_ff <= pend_list_in;
         srem_ff      <= srem_in;
         sfirst_ff    <= sfirst_in;
         short_one_ff <= short_one_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= adv && has_result;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && has_result) begin
         rsp_kind_ff  <= res_kind;
         rsp_byte_ff  <= res_byte;
         rsp_first_ff <= res_first;
         rsp_last_ff  <= res_last;
         rsp_nest_ff  <= res_nest;
         rsp_err_ff   <= res_err;
         rsp_end_ff   <= hold_last_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = rsp_kind_ff;
   assign rsp_ch.out_byte   = rsp_byte_ff;
   assign rsp_ch.item_first = rsp_first_ff;
   assign rsp_ch.item_last  = rsp_last_ff;
   assign rsp_ch.nest_level = rsp_nest_ff;
   assign rsp_ch.error_code = rsp_err_ff;
   assign rsp_ch.msg_end    = rsp_end_ff;

   // A drained byte never produces an item.
   assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && (phase_ff == PH_DRAIN)) |-> !has_result)
      else $error("drain phase produced an item");

   // Remainder bytes only follow a fully closed top item.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_REM) |-> (level == '0))
      else $error("remainder phase with open lists");

   // The stack never grows past one level beyond the depth limit.
   assert property (@(posedge clock) disable iff (reset)
      level <= LVL_W'(MAX_DEPTH + 1))
      else $error("list stack level out of range");

   // An error item carries a code and no payload fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == KIND_ERROR)) |->
         ((rsp_err_ff != ERR_NONE) && (rsp_byte_ff == 8'd0) && (rsp_nest_ff == 5'd0)))
      else $error("malformed error item");

endmodule

`default_nettype wire
